// ===== src/kmsra_pkg.sv =====
// ----------------------------------------------------------------------------
// kmsra_pkg
// Shared constants, types and saturation helper for the sparse row
// nearest-prototype assignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsra_pkg;

   localparam int MAX_PROTOS = 16;
   localparam int NUM_COLS   = 1024;
   localparam int PROTO_W    = $clog2(MAX_PROTOS);
   localparam int COL_W      = $clog2(NUM_COLS);
   localparam int ADDR_W     = PROTO_W + COL_W;
   localparam int STORE_DEPTH = MAX_PROTOS * NUM_COLS;

   localparam int FUNC_W = 2;
   localparam int VAL_W  = 16;
   localparam int NORM_W = 44;
   localparam int PROD_W = 2 * VAL_W;
   localparam int ACC_W  = 48;
   localparam int SUM_W  = ACC_W + 2;
   localparam int USED_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_ELEM = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NORM = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ROW  = 2'd2;

   localparam logic [USED_W-1:0] USED_RESET = 5'd16;
   localparam logic [PROTO_W-1:0] LAST_PROTO = PROTO_W'(MAX_PROTOS - 1);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_MAC_DRAIN,
      ST_DIST,
      ST_DIST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic [PROTO_W-1:0]       idx;
      logic signed [VAL_W-1:0]  elem;
   } mac_req_type;

   typedef struct packed {
      logic                     valid;
      logic [PROTO_W-1:0]       idx;
      logic [NORM_W-1:0]        proto_norm;
      logic signed [ACC_W-1:0]  acc;
   } dist_req_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(ACC_MAX);
      lo = SUM_W'(ACC_MIN);
      if (x > hi) begin
         return ACC_MAX;
      end else if (x < lo) begin
         return ACC_MIN;
      end
      return x[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/kmsra_proto_ram.sv =====
// ----------------------------------------------------------------------------
// kmsra_proto_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsra_proto_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/kmsra_mac_unit.sv =====
// ----------------------------------------------------------------------------
// kmsra_mac_unit
// Shared multiply-accumulate: acc[k] -= 2 * value * elem, saturating,
// with one accumulator per prototype.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsra_mac_unit
   import kmsra_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mac_req_type             mac_req,
   input  wire logic signed [VAL_W-1:0] value,
   input  wire logic                    clr_valid,
   input  wire logic [PROTO_W-1:0]      clr_idx,
   input  wire logic [PROTO_W-1:0]      acc_rd_idx,
   output logic signed [ACC_W-1:0]      acc_rd_data,
   output logic                         busy
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     pv_ff;
   logic [PROTO_W-1:0]       pidx_ff;
   logic signed [ACC_W-1:0]  acc_ff [MAX_PROTOS];
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [SUM_W-1:0]  acc_ext;
   logic signed [SUM_W-1:0]  prod2;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= mac_req.valid;
      end
      pidx_ff <= mac_req.idx;
      prod_ff <= value * mac_req.elem;
   end

   always_comb begin
      acc_ext = SUM_W'(acc_ff[pidx_ff]);
      prod2   = SUM_W'(prod_ff) <<< 1;
      acc_in  = sat_acc(acc_ext - prod2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROTOS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (clr_valid) begin
         acc_ff[clr_idx] <= '0;
      end else if (pv_ff) begin
         acc_ff[pidx_ff] <= acc_in;
      end
   end

   assign acc_rd_data = acc_ff[acc_rd_idx];
   assign busy        = pv_ff;

endmodule

`default_nettype wire

// ===== src/kmsra_dist_unit.sv =====
// ----------------------------------------------------------------------------
// kmsra_dist_unit
// Distance sum and running minimum: d = row_norm + proto_norm + acc,
// saturated, then compared against the best so far.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsra_dist_unit
   import kmsra_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dist_req_type        dist_req,
   input  wire logic [NORM_W-1:0]   row_norm,
   input  wire logic [USED_W-1:0]   used,
   output logic [PROTO_W-1:0]       best_idx,
   output logic signed [ACC_W-1:0]  best_dist,
   output logic                     busy
);

   logic signed [SUM_W-1:0] sum;
   logic signed [ACC_W-1:0] d_ff;
   logic                    v1_ff;
   logic [PROTO_W-1:0]      k1_ff;
   logic [PROTO_W-1:0]      best_idx_ff;
   logic signed [ACC_W-1:0] best_dist_ff;
   logic                    take;

   always_comb begin
      sum = $signed({{(SUM_W-NORM_W){1'b0}}, row_norm})
          + $signed({{(SUM_W-NORM_W){1'b0}}, dist_req.proto_norm})
          + SUM_W'(dist_req.acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= dist_req.valid;
      end
      k1_ff <= dist_req.idx;
      d_ff  <= sat_acc(sum);
   end

   assign take = v1_ff && (USED_W'(k1_ff) < used)
              && ((k1_ff == '0) || (d_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= k1_ff;
         best_dist_ff <= d_ff;
      end
   end

   assign best_idx  = best_idx_ff;
   assign best_dist = best_dist_ff;
   assign busy      = v1_ff;

endmodule

`default_nettype wire

// ===== src/kmeans_sparse_row_assign_unit.sv =====
// ----------------------------------------------------------------------------
// kmeans_sparse_row_assign_unit
// Nearest-prototype assignment of sparse rows (k-means assignment step).
// ----------------------------------------------------------------------------
//   req_* items load prototype elements (func 0), prototype norms (func 1)
//   or carry one row nonzero (func 2). A func 0/1/3 item does not stall the block.
//   A row nonzero visits all 16 prototypes through one shared multiply-
//   accumulate fed by the prototype RAM: reads are issued in ST_MAC, and
//   ST_MAC_DRAIN waits until the RAM read and product registers are empty.
//   On the row's last nonzero, a distance pass over all 16 prototypes
//   (ST_DIST, ST_DIST_DRAIN) follows, then ST_RESULT loads the result
//   register, and req_stall stays high until the load.
//   rsp_* carries best_proto, best_distance and same_as_previous. The result
//   sits in an output register; while rsp_stall holds it, new req items are
//   taken, and a later row end waits for the register to free up.
//   csr_data sets protos_in_use (reset 16); csr_ready is always high, and
//   writes are expected only while the block is idle.
//   Synchronous reset clears control state, accumulators and the previous
//   choice; prototype RAM and norms are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module kmeans_sparse_row_assign_unit
   import kmsra_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [FUNC_W-1:0]       req_func,
   input  wire logic [3:0]              req_proto_index,
   input  wire logic [9:0]              req_column,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic [NORM_W-1:0]       req_norm_value,
   input  wire logic                    req_row_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [3:0]                   rsp_best_proto,
   output logic signed [ACC_W-1:0]      rsp_best_distance,
   output logic                         rsp_same_as_previous,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [USED_W-1:0]       csr_data
);

   state_type               state_ff, state_in;
   logic [PROTO_W-1:0]      cnt_ff, cnt_in;
   logic [COL_W-1:0]        col_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    last_ff;
   logic [NORM_W-1:0]       row_norm_ff;
   logic [NORM_W-1:0]       norm_ff [MAX_PROTOS];
   logic [USED_W-1:0]       protos_in_use_ff;
   logic [USED_W-1:0]       used;
   logic [PROTO_W-1:0]      prev_choice_ff;
   logic                    prev_valid_ff;
   logic                    rd_valid_ff;
   logic [PROTO_W-1:0]      rd_idx_ff;
   logic                    rsp_valid_ff;
   logic [PROTO_W-1:0]      rsp_best_proto_ff;
   logic signed [ACC_W-1:0] rsp_best_distance_ff;
   logic                    rsp_same_ff;

   logic                    req_accept;
   logic                    col_ok;
   logic                    idx_ok;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [VAL_W-1:0]        ram_rd_data;
   logic                    acc_clr;
   logic                    load_rsp;
   mac_req_type             mac_req;
   dist_req_type            dist_req;
   logic signed [ACC_W-1:0] acc_rd_data;
   logic                    mac_busy;
   logic                    dist_busy;
   logic [PROTO_W-1:0]      best_idx;
   logic signed [ACC_W-1:0] best_dist;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign col_ok     = (32'(req_column) < NUM_COLS);
   assign idx_ok     = (32'(req_proto_index) < MAX_PROTOS);
   assign csr_ready  = 1'b1;

   always_comb begin
      if (protos_in_use_ff == '0) begin
         used = USED_W'(1);
      end else if (32'(protos_in_use_ff) > MAX_PROTOS) begin
         used = USED_W'(MAX_PROTOS);
      end else begin
         used = protos_in_use_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ram_rd_en = 1'b0;
      acc_clr   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_accept && req_func == FUNC_ROW) begin
               if (col_ok) begin
                  state_in = ST_MAC;
               end else if (req_row_last) begin
                  state_in = ST_DIST;
               end
            end
         end
         ST_MAC: begin
            ram_rd_en = 1'b1;
            if (cnt_ff == LAST_PROTO) begin
               cnt_in   = '0;
               state_in = ST_MAC_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MAC_DRAIN: begin
            if (!rd_valid_ff && !mac_busy) begin
               state_in = last_ff ? ST_DIST : ST_IDLE;
            end
         end
         ST_DIST: begin
            acc_clr = 1'b1;
            if (cnt_ff == LAST_PROTO) begin
               cnt_in   = '0;
               state_in = ST_DIST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIST_DRAIN: begin
            if (!dist_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         rd_valid_ff      <= 1'b0;
         protos_in_use_ff <= USED_RESET;
         prev_choice_ff   <= '0;
         prev_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= ram_rd_en;
         if (csr_valid && csr_ready) begin
            protos_in_use_ff <= csr_data;
         end
         if (load_rsp) begin
            prev_choice_ff <= best_idx;
            prev_valid_ff  <= 1'b1;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff;
      if (req_accept) begin
         col_ff      <= req_column[COL_W-1:0];
         val_ff      <= req_value;
         last_ff     <= req_row_last;
         row_norm_ff <= req_norm_value;
      end
      if (req_accept && req_func == FUNC_NORM && idx_ok) begin
         norm_ff[req_proto_index[PROTO_W-1:0]] <= req_norm_value;
      end
      if (load_rsp) begin
         rsp_best_proto_ff    <= best_idx;
         rsp_best_distance_ff <= best_dist;
         rsp_same_ff          <= prev_valid_ff && (prev_choice_ff == best_idx);
      end
   end

   assign ram_wr_en   = req_accept && req_func == FUNC_ELEM && idx_ok && col_ok;
   assign ram_wr_addr = {req_proto_index[PROTO_W-1:0], req_column[COL_W-1:0]};
   assign ram_rd_addr = {cnt_ff, col_ff};

   kmsra_proto_ram #(
      .WIDTH(VAL_W),
      .DEPTH(STORE_DEPTH)
   ) u_proto_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_value),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      mac_req.valid = rd_valid_ff;
      mac_req.idx   = rd_idx_ff;
      mac_req.elem  = $signed(ram_rd_data);
   end

   kmsra_mac_unit u_mac (
      .clock      (clock),
      .reset      (reset),
      .mac_req    (mac_req),
      .value      (val_ff),
      .clr_valid  (acc_clr),
      .clr_idx    (cnt_ff),
      .acc_rd_idx (cnt_ff),
      .acc_rd_data(acc_rd_data),
      .busy       (mac_busy)
   );

   always_comb begin
      dist_req.valid      = (state_ff == ST_DIST);
      dist_req.idx        = cnt_ff;
      dist_req.proto_norm = norm_ff[cnt_ff];
      dist_req.acc        = acc_rd_data;
   end

   kmsra_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .dist_req (dist_req),
      .row_norm (row_norm_ff),
      .used     (used),
      .best_idx (best_idx),
      .best_dist(best_dist),
      .busy     (dist_busy)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_best_proto       = rsp_best_proto_ff;
   assign rsp_best_distance    = rsp_best_distance_ff;
   assign rsp_same_as_previous = rsp_same_ff;

`ifndef SYNTHESIS
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_RESULT))
      else $error("result item raised outside result state");

   a_mac_idle_in_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIST) |-> (!rd_valid_ff && !mac_busy))
      else $error("accumulator update pending during distance pass");

   a_best_in_use: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (USED_W'(best_idx) < used))
      else $error("chosen prototype outside prototypes in use");
`endif

endmodule

`default_nettype wire

// ===== tb/kmsra_assign_checker.sv =====
// ----------------------------------------------------------------------------
// kmsra_assign_checker
// Watches the item, result and register channels of the sparse row
// nearest-prototype assignment unit. Keeps its own copy of the prototype
// store, the norms, the dot accumulators and the previous choice. Predicts
// the assignment at every accepted row end and compares each accepted result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kmsra_assign_checker
   import kmsra_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [3:0]              req_proto_index,
   input  logic [9:0]              req_column,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [NORM_W-1:0]       req_norm_value,
   input  logic                    req_row_last,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [3:0]              rsp_best_proto,
   input  logic signed [ACC_W-1:0] rsp_best_distance,
   input  logic                    rsp_same_as_previous,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [USED_W-1:0]       csr_data,
   output int                      mismatches,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]              proto;
      logic signed [ACC_W-1:0] distance;
      logic                    same;
   } assignment_type;

   logic signed [VAL_W-1:0] proto_elems [MAX_PROTOS][NUM_COLS];
   logic [NORM_W-1:0]       proto_sq_norms [MAX_PROTOS];
   logic signed [ACC_W-1:0] dot_sums [MAX_PROTOS];
   logic [3:0]              last_choice;
   logic                    last_choice_valid;
   logic [USED_W-1:0]       protos_in_use;
   assignment_type          assignments_due [$];

   function automatic logic signed [ACC_W-1:0] clamp48(input logic signed [SUM_W-1:0] x);
      if (x[SUM_W-1:ACC_W-1] == '0 || x[SUM_W-1:ACC_W-1] == '1) begin
         return x[ACC_W-1:0];
      end
      return x[SUM_W-1] ? ACC_MIN : ACC_MAX;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic predict_item();
      logic signed [2*VAL_W-1:0] prod;
      logic signed [SUM_W-1:0]   twice;
      logic signed [SUM_W-1:0]   wide;
      logic signed [ACC_W-1:0]   cand_dist;
      logic signed [ACC_W-1:0]   best_dist;
      logic [3:0]                best;
      int                        n_used;
      assignment_type            a;
      case (req_func)
         FUNC_ELEM: proto_elems[req_proto_index][req_column] = req_value;
         FUNC_NORM: proto_sq_norms[req_proto_index] = req_norm_value;
         FUNC_ROW: begin
            for (int k = 0; k < MAX_PROTOS; k++) begin
               prod = req_value * proto_elems[k][req_column];
               twice = prod;
               twice = twice * 2;
               wide = dot_sums[k];
               dot_sums[k] = clamp48(wide - twice);
            end
            if (req_row_last) begin
               if (protos_in_use == 0) begin
                  n_used = 1;
               end else if (protos_in_use > MAX_PROTOS) begin
                  n_used = MAX_PROTOS;
               end else begin
                  n_used = int'(protos_in_use);
               end
               best = '0;
               best_dist = '0;
               for (int k = 0; k < n_used; k++) begin
                  wide = $signed({6'b0, req_norm_value}) + $signed({6'b0, proto_sq_norms[k]})
                         + dot_sums[k];
                  cand_dist = clamp48(wide);
                  if (k == 0 || cand_dist < best_dist) begin
                     best_dist = cand_dist;
                     best = 4'(k);
                  end
               end
               a.proto = best;
               a.distance = best_dist;
               a.same = last_choice_valid && (last_choice == best);
               assignments_due.push_back(a);
               last_choice = best;
               last_choice_valid = 1'b1;
               foreach (dot_sums[k]) dot_sums[k] = '0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      assignment_type a;
      if (assignments_due.size() == 0) begin
         report_mismatch("unexpected result, best_proto", rsp_best_proto, 0);
      end else begin
         a = assignments_due.pop_front();
         if (rsp_best_proto !== a.proto)
            report_mismatch("best_proto", rsp_best_proto, a.proto);
         if (rsp_best_distance !== a.distance)
            report_mismatch("best_distance", rsp_best_distance, a.distance);
         if (rsp_same_as_previous !== a.same)
            report_mismatch("same_as_previous", rsp_same_as_previous, a.same);
      end
   endtask

   // handshakes are evaluated mid-cycle, ahead of the edge that completes them
   always @(negedge clock) begin
      if (reset) begin
         foreach (dot_sums[k]) dot_sums[k] = '0;
         last_choice = '0;
         last_choice_valid = 1'b0;
         protos_in_use = USED_RESET;
         assignments_due.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) protos_in_use = csr_data;
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_item();
      end
      pending = assignments_due.size();
   end

endmodule

// ===== tb/tb_kmeans_sparse_row_assign_unit.sv =====
// ----------------------------------------------------------------------------
// tb_kmeans_sparse_row_assign_unit
// Stimulus and verdict for the sparse row nearest-prototype assignment unit.
// Loads prototype columns and norms, runs a directed set of rows, then random
// phases of rows, column loads and noise under several prototype counts and
// idle patterns, including a long result hold-off. Checking is done by
// kmsra_assign_checker.
// ----------------------------------------------------------------------------
module tb_kmeans_sparse_row_assign_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import kmsra_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 100;
   localparam logic [NORM_W-1:0] NORM_MAX = '1;
   localparam logic [NORM_W-1:0] NORM_TIE = 44'h000_0400_0000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [FUNC_W-1:0]       req_func = '0;
   logic [3:0]              req_proto_index = '0;
   logic [9:0]              req_column = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [NORM_W-1:0]       req_norm_value = '0;
   logic                    req_row_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [3:0]              rsp_best_proto;
   logic signed [ACC_W-1:0] rsp_best_distance;
   logic                    rsp_same_as_previous;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [USED_W-1:0]       csr_data = '0;

   int mismatches;
   int pending;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   bit col_ready [NUM_COLS];
   int ready_cols [$];

   kmeans_sparse_row_assign_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_proto_index      (req_proto_index),
      .req_column           (req_column),
      .req_value            (req_value),
      .req_norm_value       (req_norm_value),
      .req_row_last         (req_row_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_best_proto       (rsp_best_proto),
      .rsp_best_distance    (rsp_best_distance),
      .rsp_same_as_previous (rsp_same_as_previous),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   kmsra_assign_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_proto_index      (req_proto_index),
      .req_column           (req_column),
      .req_value            (req_value),
      .req_norm_value       (req_norm_value),
      .req_row_last         (req_row_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_best_proto       (rsp_best_proto),
      .rsp_best_distance    (rsp_best_distance),
      .rsp_same_as_previous (rsp_same_as_previous),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .mismatches           (mismatches),
      .pending              (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic logic signed [VAL_W-1:0] rand_value();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic logic [NORM_W-1:0] rand_norm();
      case ($urandom_range(7))
         0: return NORM_MAX;
         1: return '0;
         2: return NORM_W'({$urandom, $urandom});
         default: return NORM_W'($urandom >> $urandom_range(0, 8));
      endcase
   endfunction

   function automatic logic [9:0] pick_ready_col();
      return 10'(ready_cols[$urandom_range(ready_cols.size() - 1)]);
   endfunction

   task automatic send_req(input logic [FUNC_W-1:0] f, input logic [3:0] p,
                           input logic [9:0] c, input logic signed [VAL_W-1:0] v,
                           input logic [NORM_W-1:0] n, input logic l);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func <= f;
      req_proto_index <= p;
      req_column <= c;
      req_value <= v;
      req_norm_value <= n;
      req_row_last <= l;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_protos_in_use(input logic [USED_W-1:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_column(input logic [9:0] c);
      for (int k = 0; k < MAX_PROTOS; k++)
         send_req(FUNC_ELEM, 4'(k), c, rand_value(), rand_norm(), 1'($urandom));
      if (!col_ready[c]) begin
         col_ready[c] = 1'b1;
         ready_cols.push_back(int'(c));
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(2))
         0: send_req(FUNC_ELEM, 4'($urandom), 10'($urandom), rand_value(), rand_norm(),
                     1'($urandom));
         1: send_req(FUNC_NORM, 4'($urandom), 10'($urandom), rand_value(), rand_norm(),
                     1'($urandom));
         default: send_req(FUNC_UNUSED, 4'($urandom), 10'($urandom), rand_value(),
                           rand_norm(), 1'($urandom));
      endcase
   endtask

   task automatic send_row(output int count);
      int len;
      logic signed [VAL_W-1:0] v;
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      count = len;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(15) == 0) begin
            send_noise();
            count++;
         end
         v = ($urandom_range(19) == 0) ? '0 : rand_value();
         send_req(FUNC_ROW, 4'($urandom), pick_ready_col(), v, rand_norm(), i == len - 1);
      end
   endtask

   task automatic run_phase(input int n_items, input bit with_hold);
      int sent;
      int n;
      int pick;
      bit paused;
      sent = 0;
      paused = 1'b0;
      if (with_hold) hold_trigger <= hold_trigger + 1;
      while (sent < n_items) begin
         if (!paused && sent >= n_items / 2) begin
            wait_results();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_row(n);
         end else if (pick < 79) begin
            load_column(10'($urandom));
            n = MAX_PROTOS;
         end else begin
            send_noise();
            n = 1;
         end
         sent += n;
      end
   endtask

   initial begin
      logic [USED_W-1:0] cfg;
      int cfg_values [6];
      cfg_values = '{1, 16, 0, 31, 7, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 7;
      rsp_idle_pct <= 52;

      // equal norms everywhere so zero rows tie on every prototype
      for (int k = 0; k < MAX_PROTOS; k++)
         send_req(FUNC_NORM, 4'(k), 10'($urandom), rand_value(), NORM_TIE, 1'($urandom));
      load_column(10'd0);
      load_column(10'd1023);

      send_req(FUNC_UNUSED, 4'hF, 10'h3FF, 16'sh8000, NORM_MAX, 1'b1);
      send_req(FUNC_ROW, 4'h0, 10'd0, 16'sh0000, '0, 1'b1);
      send_req(FUNC_ROW, 4'hF, 10'd1023, 16'sh0000, NORM_MAX, 1'b1);
      send_req(FUNC_NORM, 4'hF, 10'd0, 16'sh0000, '0, 1'b0);
      send_req(FUNC_NORM, 4'h0, 10'd0, 16'sh0000, NORM_MAX, 1'b0);
      send_req(FUNC_ELEM, 4'hF, 10'd0, 16'sh7FFF, '0, 1'b0);
      send_req(FUNC_ELEM, 4'h3, 10'd1023, 16'sh8000, NORM_MAX, 1'b1);
      send_req(FUNC_ROW, 4'h0, 10'd0, 16'sh7FFF, NORM_MAX, 1'b0);
      send_req(FUNC_ROW, 4'h0, 10'd1023, 16'sh8000, '0, 1'b1);
      send_req(FUNC_ROW, 4'h0, 10'd0, 16'sh8000, 44'h123_4567_89AB, 1'b1);
      send_req(FUNC_UNUSED, 4'h0, 10'd0, 16'sh0000, '0, 1'b0);
      send_req(FUNC_ROW, 4'h0, 10'd1023, 16'sh0001, 44'd1, 1'b1);
      send_req(FUNC_ROW, 4'h0, 10'd0, 16'sh0000, '0, 1'b1);

      for (int p = 0; p < 6; p++) begin
         settle();
         cfg = (p == 5) ? USED_W'($urandom_range(1, MAX_PROTOS)) : USED_W'(cfg_values[p]);
         write_protos_in_use(cfg);
         if (p < 2) begin
            send_idle_pct = 7;
            rsp_idle_pct <= 52;
         end else if (p < 4) begin
            send_idle_pct = 52;
            rsp_idle_pct <= 7;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         run_phase(PHASE_ITEMS, p == 0 || p == 4);
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
